FILE: rtl/core/url_percent_decoder_macros.svh
// Assertion macros used by the output stage of the URL percent decoder.
`ifndef URL_PERCENT_DECODER_MACROS_SVH
`define URL_PERCENT_DECODER_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define UPD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define UPD_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/upd_pkg.sv
// Package with types, constants and helper functions of the URL percent decoder.
`timescale 1ns / 1ps
package upd_pkg;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_PERCENT,
      PHASE_DIGIT
   } upd_phase_type;

   // Results of one item, in order, with their number and the end of string flag.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] data;
      logic [1:0]                  count;
      logic                        str_last;
   } upd_bundle_type;

   function automatic logic is_hex(input logic [7:0] c);
      logic res;
      res = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
            (c >= 8'h61 && c <= 8'h66);
      return res;
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      if (c >= 8'h61) begin
         v = c - 8'h57;
      end else if (c >= 8'h41) begin
         v = c - 8'h37;
      end else begin
         v = c - 8'h30;
      end
      return v[3:0];
   endfunction

endpackage

FILE: rtl/core/upd_req_if.sv
// Handshake channel that carries one source byte per item.
`timescale 1ns / 1ps
interface upd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: rtl/core/upd_rsp_if.sv
// Handshake channel that carries one decoded byte per item.
`timescale 1ns / 1ps
interface upd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       string_end;

   modport source (output valid, output out_byte, output run_last, output string_end,
                   input ready);
   modport sink (input valid, input out_byte, input run_last, input string_end,
                 output ready);
endinterface

FILE: rtl/core/upd_front.sv
// Front end that tracks escapes and turns each source byte into a bundle of results.
`timescale 1ns / 1ps
module upd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [7:0]             in_byte,
   input  logic                   in_last,
   output logic                   in_ready,
   output logic                   push_valid,
   output upd_pkg::upd_bundle_type push_bundle,
   input  logic                   push_ready
);

   upd_pkg::upd_phase_type phase_ff;
   upd_pkg::upd_phase_type phase_in;
   logic [7:0]             held_ff;
   logic [7:0]             held_in;
   logic                   accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= upd_pkg::PHASE_IDLE;
         held_ff  <= 8'h00;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   always_comb begin
      logic [1:0]                                n;
      logic [upd_pkg::MAX_RESULTS-1:0][7:0]      arr;
      logic                                      do_fresh;
      logic                                      hex;
      n        = 2'd0;
      arr      = '0;
      do_fresh = 1'b0;
      phase_in = upd_pkg::PHASE_IDLE;
      held_in  = held_ff;
      hex      = upd_pkg::is_hex(in_byte);
      unique case (phase_ff)
         upd_pkg::PHASE_PERCENT: begin
            if (hex) begin
               phase_in = upd_pkg::PHASE_DIGIT;
               held_in  = in_byte;
            end else begin
               arr[n]   = upd_pkg::CH_PERCENT;
               n        = n + 2'd1;
               do_fresh = 1'b1;
            end
         end
         upd_pkg::PHASE_DIGIT: begin
            if (hex) begin
               arr[n]  = {upd_pkg::hex_val(held_ff), upd_pkg::hex_val(in_byte)};
               n       = n + 2'd1;
               held_in = 8'h00;
            end else begin
               arr[n]   = upd_pkg::CH_PERCENT;
               n        = n + 2'd1;
               arr[n]   = held_ff;
               n        = n + 2'd1;
               held_in  = 8'h00;
               do_fresh = 1'b1;
            end
         end
         default: begin
            do_fresh = 1'b1;
         end
      endcase
      if (do_fresh) begin
         priority if (in_byte == upd_pkg::CH_PERCENT) begin
            phase_in = upd_pkg::PHASE_PERCENT;
         end else if (in_byte == upd_pkg::CH_PLUS) begin
            arr[n] = upd_pkg::CH_SPACE;
            n      = n + 2'd1;
         end else begin
            arr[n] = in_byte;
            n      = n + 2'd1;
         end
      end
      if (in_last) begin
         if (phase_in == upd_pkg::PHASE_PERCENT) begin
            arr[n] = upd_pkg::CH_PERCENT;
            n      = n + 2'd1;
         end else if (phase_in == upd_pkg::PHASE_DIGIT) begin
            arr[n] = upd_pkg::CH_PERCENT;
            n      = n + 2'd1;
            arr[n] = held_in;
            n      = n + 2'd1;
         end
         phase_in = upd_pkg::PHASE_IDLE;
         held_in  = 8'h00;
      end
      push_bundle.data     = arr;
      push_bundle.count    = n;
      push_bundle.str_last = in_last;
      push_valid           = in_valid && (n != 2'd0);
   end

   assign in_ready = push_ready;
   assign accept   = in_valid && in_ready;

endmodule

FILE: rtl/core/upd_queue.sv
// Short queue of result bundles between the front end and the output stage.
`timescale 1ns / 1ps
module upd_queue #(
   parameter int DEPTH = upd_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  upd_pkg::upd_bundle_type push_bundle,
   output logic                    push_ready,
   output logic                    pop_valid,
   output upd_pkg::upd_bundle_type pop_bundle,
   input  logic                    pop
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   upd_pkg::upd_bundle_type mem_ff [DEPTH];
   logic [PW-1:0]           wr_ptr_ff;
   logic [PW-1:0]           wr_ptr_in;
   logic [PW-1:0]           rd_ptr_ff;
   logic [PW-1:0]           rd_ptr_in;
   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           count_in;
   logic                    do_push;
   logic                    do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_bundle = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

FILE: rtl/core/upd_back.sv
// Output stage that sends the results of each bundle one item at a time.
`timescale 1ns / 1ps
`include "url_percent_decoder_macros.svh"
module upd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  upd_pkg::upd_bundle_type q_head,
   output logic                    q_pop,
   output logic                    out_valid,
   output logic [7:0]              out_byte,
   output logic                    out_run_last,
   output logic                    out_string_end,
   input  logic                    out_ready
);

   logic [1:0] idx_ff;
   logic [1:0] idx_in;
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       run_last_ff;
   logic       string_end_ff;
   logic       load;
   logic       final_one;

   assign load      = q_valid && (!valid_ff || out_ready);
   assign final_one = (idx_ff == (q_head.count - 2'd1));
   assign q_pop     = load && final_one;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = final_one ? 2'd0 : idx_ff + 2'd1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff       <= q_head.data[idx_ff];
         run_last_ff   <= final_one;
         string_end_ff <= final_one && q_head.str_last;
      end
   end

   assign out_valid      = valid_ff;
   assign out_byte       = byte_ff;
   assign out_run_last   = run_last_ff;
   assign out_string_end = string_end_ff;

   `UPD_ASSERT(a_idx_in_bundle, !q_valid || (idx_ff < q_head.count), "Result index beyond bundle.")
   `UPD_ASSERT(a_end_is_final, !(valid_ff && string_end_ff) || run_last_ff, "String end not final.")
   `UPD_ASSERT_NEXT(a_pop_rewinds, q_pop, idx_ff == 2'd0, "Index not cleared after bundle.")

endmodule

FILE: rtl/core/url_percent_decoder.sv
// Top level of the URL percent decoder.
//
//   Channel   Direction  Payload                          Item
//   req_ch    in         in_byte[7:0], in_last            one source byte
//   rsp_ch    out        out_byte[7:0], run_last, string_end  one decoded byte
//
// A source byte is taken in every cycle while the bundle queue has room.
// Each source byte yields zero to three decoded bytes; the output register sends
// one per cycle while the receiver is ready, so plain text moves at one byte per cycle.
// Reset is synchronous and clears the escape state, the queue and the output valid flag.
// The queue lets the input keep flowing while the output is stalled, until the queue is full.
`timescale 1ns / 1ps
module url_percent_decoder #(
   parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH
) (
   input logic       clock,
   input logic       reset,
   upd_req_if.sink   req_ch,
   upd_rsp_if.source rsp_ch
);

   logic                    push_valid;
   logic                    push_ready;
   upd_pkg::upd_bundle_type push_bundle;
   logic                    q_valid;
   upd_pkg::upd_bundle_type q_head;
   logic                    q_pop;

   upd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_ch.valid),
      .in_byte     (req_ch.in_byte),
      .in_last     (req_ch.in_last),
      .in_ready    (req_ch.ready),
      .push_valid  (push_valid),
      .push_bundle (push_bundle),
      .push_ready  (push_ready)
   );

   upd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_bundle (push_bundle),
      .push_ready  (push_ready),
      .pop_valid   (q_valid),
      .pop_bundle  (q_head),
      .pop         (q_pop)
   );

   upd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .out_valid      (rsp_ch.valid),
      .out_byte       (rsp_ch.out_byte),
      .out_run_last   (rsp_ch.run_last),
      .out_string_end (rsp_ch.string_end),
      .out_ready      (rsp_ch.ready)
   );

endmodule

FILE: test/testbench.sv
// Self-checking testbench of the URL percent decoder with directed and random strings.
`timescale 1ns / 1ps
module testbench;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 16;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int PHASE_ITEMS     = 107;
   localparam logic PINNED = 1'b1;
   localparam logic FREE   = 1'b0;

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       string_end;
   } decoded_type;

   typedef struct packed {
      logic [7:0]      src;
      logic            ends;
      logic            pinned;
      logic [1:0]      count;
      logic [0:2][7:0] data;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   upd_req_if req ();
   upd_rsp_if rsp ();

   url_percent_decoder uut (.clock(clock), .reset(reset), .req_ch(req), .rsp_ch(rsp));

   upd_pkg::upd_phase_type esc_phase;
   logic [7:0]             esc_digit;
   logic [7:0]             step_bytes[$];
   decoded_type            expected_q[$];
   dir_row_type            directed_rows[$];
   dir_row_type            pinned_q[$];

   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic hold_armed     = 1'b0;
   logic hold_done      = 1'b0;
   int   hold_cycles    = 0;
   int   error_count    = 0;
   int   checked_count  = 0;
   int   sent_count     = 0;
   int   string_count   = 0;
   int   quiet_cycles   = 0;

   always #1 clock = ~clock;

   function automatic logic is_hex_char(input logic [7:0] c);
      logic [7:0] folded;
      folded = c | 8'h20;
      return (c >= "0" && c <= "9") || (folded >= "a" && folded <= "f");
   endfunction

   function automatic logic [3:0] nibble(input logic [7:0] c);
      if (c <= "9") begin
         return c[3:0];
      end
      return c[3:0] + 4'd9;
   endfunction

   function automatic void emit_byte(input logic [7:0] c);
      if (step_bytes.size() < upd_pkg::MAX_RESULTS) begin
         step_bytes.push_back(c);
      end
   endfunction

   function automatic void take_fresh(input logic [7:0] c);
      if (c == upd_pkg::CH_PERCENT) begin
         esc_phase = upd_pkg::PHASE_PERCENT;
      end else if (c == upd_pkg::CH_PLUS) begin
         emit_byte(upd_pkg::CH_SPACE);
      end else begin
         emit_byte(c);
      end
   endfunction

   // Works out the decoded bytes that one source byte releases.
   function automatic void decode_item(input logic [7:0] c, input logic ends);
      step_bytes.delete();
      case (esc_phase)
         upd_pkg::PHASE_PERCENT: begin
            if (is_hex_char(c)) begin
               esc_digit = c;
               esc_phase = upd_pkg::PHASE_DIGIT;
            end else begin
               emit_byte(upd_pkg::CH_PERCENT);
               esc_phase = upd_pkg::PHASE_IDLE;
               take_fresh(c);
            end
         end
         upd_pkg::PHASE_DIGIT: begin
            if (is_hex_char(c)) begin
               emit_byte({nibble(esc_digit), nibble(c)});
            end else begin
               emit_byte(upd_pkg::CH_PERCENT);
               emit_byte(esc_digit);
            end
            esc_phase = upd_pkg::PHASE_IDLE;
            esc_digit = 8'h00;
            if (!is_hex_char(c)) begin
               take_fresh(c);
            end
         end
         default: begin
            esc_phase = upd_pkg::PHASE_IDLE;
            take_fresh(c);
         end
      endcase
      if (ends) begin
         if (esc_phase == upd_pkg::PHASE_PERCENT) begin
            emit_byte(upd_pkg::CH_PERCENT);
         end else if (esc_phase == upd_pkg::PHASE_DIGIT) begin
            emit_byte(upd_pkg::CH_PERCENT);
            emit_byte(esc_digit);
         end
         esc_phase = upd_pkg::PHASE_IDLE;
         esc_digit = 8'h00;
      end
   endfunction

   function automatic logic [7:0] random_hex();
      int v;
      v = $urandom_range(0, 21);
      if (v < 10) begin
         return 8'h30 + 8'(v);
      end else if (v < 16) begin
         return 8'h61 + 8'(v - 10);
      end
      return 8'h41 + 8'(v - 16);
   endfunction

   task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
      error_count++;
      $display("Mismatch in %s at %0t: expected %h, got %h", what, $time, want, got);
   endtask

   task automatic send_item(input logic [7:0] c, input logic ends);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid   = 1'b1;
      req.in_byte = c;
      req.in_last = ends;
      do @(posedge clock); while (req.ready !== 1'b1);
      sent_count++;
      @(negedge clock);
   endtask

   // Mostly well-formed escapes and plain text, with some broken or unfinished escapes.
   task automatic send_string();
      logic [7:0] chars[$];
      logic [7:0] plain;
      int pieces;
      int p;
      int k;
      pieces = $urandom_range(1, 8);
      for (p = 0; p < pieces; p++) begin
         k = $urandom_range(0, 99);
         if (k < 45) begin
            plain = 8'($urandom_range(1, 255));
            chars.push_back(plain);
         end else if (k < 70) begin
            chars.push_back(upd_pkg::CH_PERCENT);
            chars.push_back(random_hex());
            chars.push_back(random_hex());
         end else if (k < 80) begin
            chars.push_back(upd_pkg::CH_PLUS);
         end else if (k < 90) begin
            chars.push_back(upd_pkg::CH_PERCENT);
            chars.push_back(random_hex());
         end else begin
            chars.push_back(upd_pkg::CH_PERCENT);
         end
      end
      for (k = 0; k < chars.size(); k++) begin
         send_item(chars[k], k == chars.size() - 1);
      end
      string_count++;
   endtask

   always @(negedge clock) begin
      if (hold_armed && !hold_done) begin
         rsp.ready = 1'b0;
         hold_cycles++;
         if (hold_cycles >= HOLD_OFF_CYCLES) begin
            hold_done = 1'b1;
         end
      end else begin
         rsp.ready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      decoded_type want;
      dir_row_type pin;
      int n;
      if (reset) begin
         esc_phase = upd_pkg::PHASE_IDLE;
         esc_digit = 8'h00;
         quiet_cycles = 0;
      end else begin
         if (req.valid && req.ready) begin
            decode_item(req.in_byte, req.in_last);
            if (pinned_q.size() != 0) begin
               pin = pinned_q.pop_front();
               if (pin.pinned) begin
                  step_bytes.delete();
                  for (n = 0; n < pin.count; n++) begin
                     step_bytes.push_back(pin.data[n]);
                  end
               end
            end
            for (n = 0; n < step_bytes.size(); n++) begin
               want.data       = step_bytes[n];
               want.run_last   = (n == step_bytes.size() - 1);
               want.string_end = want.run_last && req.in_last;
               expected_q.push_back(want);
            end
         end
         if (rsp.valid && rsp.ready) begin
            checked_count++;
            if (expected_q.size() == 0) begin
               report("unexpected item", 8'h00, rsp.out_byte);
            end else begin
               want = expected_q.pop_front();
               if (rsp.out_byte !== want.data) begin
                  report("out_byte", want.data, rsp.out_byte);
               end
               if (rsp.run_last !== want.run_last) begin
                  report("run_last", {7'd0, want.run_last}, {7'd0, rsp.run_last});
               end
               if (rsp.string_end !== want.string_end) begin
                  report("string_end", {7'd0, want.string_end}, {7'd0, rsp.string_end});
               end
            end
         end
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      int k;
      int phase;
      int target;
      req.valid   = 1'b0;
      req.in_byte = 8'h00;
      req.in_last = 1'b0;
      reset       = 1'b1;

      //                        src    last  kind    n     results
      directed_rows.push_back({8'h61, 1'b0, PINNED, 2'd1, 8'h61, 8'h00, 8'h00});
      directed_rows.push_back({8'h2B, 1'b0, PINNED, 2'd1, 8'h20, 8'h00, 8'h00});
      directed_rows.push_back({8'hFF, 1'b0, PINNED, 2'd1, 8'hFF, 8'h00, 8'h00});
      directed_rows.push_back({8'h25, 1'b0, PINNED, 2'd0, 8'h00, 8'h00, 8'h00});
      directed_rows.push_back({8'h61, 1'b0, FREE,   2'd0, 8'h00, 8'h00, 8'h00});
      directed_rows.push_back({8'h46, 1'b0, PINNED, 2'd1, 8'hAF, 8'h00, 8'h00});
      directed_rows.push_back({8'h25, 1'b0, PINNED, 2'd0, 8'h00, 8'h00, 8'h00});
      directed_rows.push_back({8'h30, 1'b0, FREE,   2'd0, 8'h00, 8'h00, 8'h00});
      directed_rows.push_back({8'h30, 1'b1, PINNED, 2'd1, 8'h00, 8'h00, 8'h00});
      directed_rows.push_back({8'h25, 1'b0, PINNED, 2'd0, 8'h00, 8'h00, 8'h00});
      directed_rows.push_back({8'h67, 1'b0, PINNED, 2'd2, 8'h25, 8'h67, 8'h00});
      directed_rows.push_back({8'h25, 1'b0, PINNED, 2'd0, 8'h00, 8'h00, 8'h00});
      directed_rows.push_back({8'h41, 1'b0, FREE,   2'd0, 8'h00, 8'h00, 8'h00});
      directed_rows.push_back({8'h2B, 1'b0, PINNED, 2'd3, 8'h25, 8'h41, 8'h20});
      directed_rows.push_back({8'h25, 1'b0, PINNED, 2'd0, 8'h00, 8'h00, 8'h00});
      directed_rows.push_back({8'h25, 1'b0, PINNED, 2'd1, 8'h25, 8'h00, 8'h00});
      directed_rows.push_back({8'h62, 1'b0, FREE,   2'd0, 8'h00, 8'h00, 8'h00});
      directed_rows.push_back({8'h25, 1'b0, PINNED, 2'd2, 8'h25, 8'h62, 8'h00});
      directed_rows.push_back({8'h5A, 1'b1, PINNED, 2'd2, 8'h25, 8'h5A, 8'h00});
      directed_rows.push_back({8'h25, 1'b1, PINNED, 2'd1, 8'h25, 8'h00, 8'h00});
      directed_rows.push_back({8'h01, 1'b1, PINNED, 2'd1, 8'h01, 8'h00, 8'h00});
      directed_rows.push_back({8'h25, 1'b0, PINNED, 2'd0, 8'h00, 8'h00, 8'h00});
      directed_rows.push_back({8'h37, 1'b0, FREE,   2'd0, 8'h00, 8'h00, 8'h00});
      directed_rows.push_back({8'h25, 1'b1, PINNED, 2'd3, 8'h25, 8'h37, 8'h25});

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (k = 0; k < directed_rows.size(); k++) begin
         pinned_q.push_back(directed_rows[k]);
         send_item(directed_rows[k].src, directed_rows[k].ends);
      end

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 59;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 59;
            end
            default: begin
               send_idle_pct  = 23;
               recv_stall_pct = 23;
            end
         endcase
         if (phase == 0) begin
            hold_armed = 1'b1;
         end
         target = sent_count + PHASE_ITEMS;
         while (sent_count < target) begin
            send_string();
         end
         req.valid = 1'b0;
         while (expected_q.size() != 0) begin
            @(posedge clock);
         end
         @(negedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d source bytes (%0d directed, %0d random strings), checked %0d outputs,",
               sent_count, directed_rows.size(), string_count, checked_count);
      $display("across four idle and stall mixes with one long output hold-off.");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
